FILE: rtl/core/k_nearest_neighbor_search_core_defines.svh
// Assertion macros shared by the k-nearest-neighbor search core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef K_NEAREST_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`define K_NEAREST_NEIGHBOR_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KNN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KNN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/knn_pkg.sv
// Shared constants, codes and types of the k-nearest-neighbor search core.
// No dependencies; every other file but the macro header imports it.
package knn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_K      = 20;
    localparam int COORD_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_POINTS);       // stored point index
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);   // point count
    localparam int SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int K_W    = $clog2(MAX_K + 1);        // neighbor count
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 2;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'b0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        point_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // One candidate entering the top-k list
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } cand_t;

endpackage

FILE: rtl/core/knn_chan_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on knn_pkg.
interface knn_cmd_if import knn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [5:0]         query_index;

    modport source (output valid, func, coord_x, coord_y, coord_z, query_index,
                    input ready);
    modport sink   (input valid, func, coord_x, coord_y, coord_z, query_index,
                    output ready);
endinterface

interface knn_res_if import knn_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [5:0]  source_index;
    logic [5:0]  neighbor_index;
    logic [4:0]  rank;
    logic [33:0] distance_sq;
    logic        found;
    logic        last;

    modport source (output valid, source_index, neighbor_index, rank, distance_sq,
                    found, last, input ready);
    modport sink   (input valid, source_index, neighbor_index, rank, distance_sq,
                    found, last, output ready);
endinterface

FILE: rtl/core/knn_point_mem.sv
// Point store: single-port-write, single-read synchronous RAM with a registered read.
// Depends on knn_pkg.
module knn_point_mem import knn_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output point_t   rd_data
);

    point_t mem [MAX_POINTS];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/knn_dist.sv
// Three-stage squared-distance pipeline: subtract, square, sum.
// Depends on knn_pkg.
module knn_dist import knn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  point_t           ref_pt,
    input  logic             in_vld,
    input  logic [IDX_W-1:0] in_idx,
    input  point_t           in_pt,
    output cand_t            cand,
    output logic             busy
);

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [SQ_W-1:0]          s2_sx_reg, s2_sy_reg, s2_sz_reg;
    logic [DIST_W-1:0]        s3_dist_reg;
    logic signed [2*DIFF_W-1:0] px, py, pz;

    always_comb
    begin
        px = s1_dx_reg * s1_dx_reg;
        py = s1_dy_reg * s1_dy_reg;
        pz = s1_dz_reg * s1_dz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        s1_dx_reg  <= DIFF_W'(ref_pt.x) - DIFF_W'(in_pt.x);
        s1_dy_reg  <= DIFF_W'(ref_pt.y) - DIFF_W'(in_pt.y);
        s1_dz_reg  <= DIFF_W'(ref_pt.z) - DIFF_W'(in_pt.z);

        // |d| < 2^COORD_BITS, so each square fits in SQ_W bits
        s2_idx_reg <= s1_idx_reg;
        s2_sx_reg  <= px[SQ_W-1:0];
        s2_sy_reg  <= py[SQ_W-1:0];
        s2_sz_reg  <= pz[SQ_W-1:0];

        s3_idx_reg  <= s2_idx_reg;
        s3_dist_reg <= DIST_W'(s2_sx_reg) + DIST_W'(s2_sy_reg) + DIST_W'(s2_sz_reg);
    end

    assign cand.vld  = s3_vld_reg;
    assign cand.idx  = s3_idx_reg;
    assign cand.dsq  = s3_dist_reg;
    assign busy      = s1_vld_reg | s2_vld_reg | s3_vld_reg;

endmodule

FILE: rtl/core/knn_topk.sv
// Sorted top-k list: one insertion per cycle into a row of slots, read by slot.
// Depends on knn_pkg and the assertion macro header.
`include "k_nearest_neighbor_search_core_defines.svh"

module knn_topk import knn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic [K_W-1:0]    k,
    input  cand_t             cand,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic [K_W-1:0]    cnt,
    output logic [IDX_W-1:0]  rd_idx,
    output logic [DIST_W-1:0] rd_dist
);

    logic [DIST_W-1:0] slot_d_reg [MAX_K];
    logic [IDX_W-1:0]  slot_i_reg [MAX_K];
    logic [K_W-1:0]    cnt_reg;
    logic [MAX_K-1:0]  greater;
    logic [MAX_K-1:0]  prev_greater;

    // A slot moves when it is empty or holds a strictly larger distance;
    // ties keep the earlier (lower) index ahead.
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            greater[i] = (K_W'(i) < k) &&
                         ((K_W'(i) >= cnt_reg) || (slot_d_reg[i] > cand.dsq));
        end
        prev_greater = greater << 1;
    end

    for (genvar i = 0; i < MAX_K; i++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (cand.vld && greater[i])
            begin
                if (!prev_greater[i])
                begin
                    slot_d_reg[i] <= cand.dsq;
                    slot_i_reg[i] <= cand.idx;
                end
                else
                begin
                    if (i > 0)
                    begin
                        slot_d_reg[i] <= slot_d_reg[(i > 0) ? i - 1 : 0];
                        slot_i_reg[i] <= slot_i_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            cnt_reg <= '0;
        end
        else if (cand.vld && (cnt_reg < k))
        begin
            cnt_reg <= cnt_reg + K_W'(1);
        end
    end

    assign cnt     = cnt_reg;
    assign rd_idx  = slot_i_reg[rd_slot];
    assign rd_dist = slot_d_reg[rd_slot];

    `KNN_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= K_W'(MAX_K), "top-k count above MAX_K")
    `KNN_ASSERT_NEXT(a_clear_empties, clear, cnt_reg == '0, "top-k list not empty after clear")
    `KNN_ASSERT_NOW(a_sorted_head, cnt_reg >= K_W'(2), slot_d_reg[0] <= slot_d_reg[1], "top-k list out of order")

endmodule

FILE: rtl/core/k_nearest_neighbor_search_core.sv
// Brute-force 3-D k-nearest-neighbor search core: controller, config port, result register.
// Depends on knn_pkg, knn_chan_if, knn_point_mem, knn_dist, knn_topk and the macro header.
//
// Clear, append and no-op items are handled as soon as they are taken. A query of a stored
// point reads the point, then streams the stored points out of the point RAM one per
// cycle, all but the query point itself going through a three-stage squared-distance
// pipeline into a sorted top-k list, and finally hands out the results through the
// output register, one per cycle while the receiver takes them.
// A query with a bad index skips the scan and returns its single found=0 result.
// A new command is taken only while no query is in progress; the output
// register holds the last result independently. neighbor_count (byte address 0)
// should be written only while the core is idle; writes clamp into 1..20.
`include "k_nearest_neighbor_search_core_defines.svh"

module k_nearest_neighbor_search_core import knn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    knn_cmd_if.sink               cmd,
    knn_res_if.source             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_REF   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  total_reg;
    logic [K_W-1:0]    nc_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [IDX_W-1:0]  j_reg;
    logic              bad_reg;
    logic [SLOT_W-1:0] e_reg;
    logic              ref_pend_reg;
    point_t            ref_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic              out_vld_reg;
    logic [IDX_W-1:0]  out_src_reg;
    logic [IDX_W-1:0]  out_nb_reg;
    logic [4:0]        out_rank_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_found_reg;
    logic              out_last_reg;

    mem_req_t          mem_req;
    point_t            rd_data;
    cand_t             cand;
    logic              dist_busy;
    logic [K_W-1:0]    topk_cnt;
    logic [IDX_W-1:0]  topk_idx;
    logic [DIST_W-1:0] topk_dist;

    logic              cmd_acc;
    logic              q_start;
    logic              q_bad;
    logic              scan_done;
    logic              emit_load;
    logic              emit_none;
    logic              emit_last;
    logic              cfg_wr;
    logic [K_W-1:0]    cfg_val;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign q_bad     = CNT_W'(cmd.query_index) >= total_reg;
    assign q_start   = cmd_acc && (cmd.func == FUNC_QUERY) && !q_bad;
    assign scan_done = (CNT_W'(j_reg) + CNT_W'(1)) == total_reg;
    assign emit_load = (state_reg == ST_EMIT) && (!out_vld_reg || res.ready);
    assign emit_none = bad_reg || (topk_cnt == '0);
    assign emit_last = emit_none || ((K_W'(e_reg) + K_W'(1)) == topk_cnt);

    // Point RAM port: append writes, query reads the reference then every point
    always_comb
    begin
        mem_req         = '0;
        mem_req.wr_addr = total_reg[IDX_W-1:0];
        mem_req.wr_data = '{x: cmd.coord_x[COORD_BITS-1:0],
                            y: cmd.coord_y[COORD_BITS-1:0],
                            z: cmd.coord_z[COORD_BITS-1:0]};
        mem_req.wr_en   = cmd_acc && (cmd.func == FUNC_APPEND) &&
                          (total_reg < CNT_W'(MAX_POINTS));
        mem_req.rd_en   = (state_reg == ST_REF) || (state_reg == ST_SCAN);
        mem_req.rd_addr = (state_reg == ST_REF) ? q_reg : j_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && (cmd.func == FUNC_QUERY))
                begin
                    state_next = q_bad ? ST_EMIT : ST_REF;
                end
            end
            ST_REF:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !dist_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            ref_pend_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ref_pend_reg <= (state_reg == ST_REF);
            rd_vld_reg   <= (state_reg == ST_SCAN) && (j_reg != q_reg);
            if (cmd_acc && (cmd.func == FUNC_CLEAR))
            begin
                total_reg <= '0;
            end
            else if (mem_req.wr_en)
            begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (emit_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            q_reg   <= cmd.query_index;
            bad_reg <= q_bad;
            e_reg   <= '0;
        end
        if (state_reg == ST_REF)
        begin
            j_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            j_reg <= j_reg + IDX_W'(1);
        end
        if (ref_pend_reg)
        begin
            ref_reg <= rd_data;
        end
        rd_idx_reg <= j_reg;
        if (emit_load)
        begin
            e_reg         <= e_reg + SLOT_W'(1);
            out_src_reg   <= q_reg;
            out_nb_reg    <= emit_none ? '0 : topk_idx;
            out_rank_reg  <= emit_none ? '0 : 5'(e_reg);
            out_dist_reg  <= emit_none ? '0 : topk_dist;
            out_found_reg <= !emit_none;
            out_last_reg  <= emit_last;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.source_index   = out_src_reg;
    assign res.neighbor_index = out_nb_reg;
    assign res.rank           = out_rank_reg;
    assign res.distance_sq    = out_dist_reg;
    assign res.found          = out_found_reg;
    assign res.last           = out_last_reg;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite &&
                     (paddr[APB_ADDR_W-1:2] == REG_NEIGHBOR_COUNT);
    assign cfg_val = pwdata[K_W-1:0];
    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_NEIGHBOR_COUNT) ?
                     APB_DATA_W'(nc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= K_W'(1);
        end
        else if (cfg_wr)
        begin
            priority if (cfg_val == '0)
            begin
                nc_reg <= K_W'(1);
            end
            else if (cfg_val > K_W'(MAX_K))
            begin
                nc_reg <= K_W'(MAX_K);
            end
            else
            begin
                nc_reg <= cfg_val;
            end
        end
    end

    knn_point_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    knn_dist u_dist
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ref_pt (ref_reg),
        .in_vld (rd_vld_reg),
        .in_idx (rd_idx_reg),
        .in_pt  (rd_data),
        .cand   (cand),
        .busy   (dist_busy)
    );

    knn_topk u_topk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (q_start),
        .k       (nc_reg),
        .cand    (cand),
        .rd_slot (e_reg),
        .cnt     (topk_cnt),
        .rd_idx  (topk_idx),
        .rd_dist (topk_dist)
    );

    `KNN_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= CNT_W'(MAX_POINTS), "point count above capacity")
    `KNN_ASSERT_NOW(a_emit_drained, state_reg == ST_EMIT, !dist_busy && !rd_vld_reg, "results emitted while distance pipeline busy")
    `KNN_ASSERT_NOW(a_notfound_last, out_vld_reg && !out_found_reg, out_last_reg, "found=0 result not marked last")
    `KNN_ASSERT_NOW(a_write_idle, mem_req.wr_en, state_reg == ST_IDLE, "point write outside idle")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for k_nearest_neighbor_search_core: walks a directed table of items,
// then random point clouds under several neighbor_count settings, checking every result
// item against the in-bench top-k predictor or a typed row. Needs knn_pkg and knn_chan_if.
module tb;
    import knn_pkg::*;

    localparam logic [FUNC_W-1:0]     FUNC_NOP            = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_NEIGHBOR_COUNT = {REG_NEIGHBOR_COUNT, 2'b00};
    localparam logic [DIST_W-1:0]     FAR_CORNER_DIST     = 34'd12884508675;
    localparam int RANDOM_ITEMS  = 190;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = MAX_POINTS + MAX_K + 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 12_000_000;
    localparam int K_SWEEP [8]   = '{20, 1, 31, 2, 0, 21, 7, 13};

    typedef struct packed {
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  nbr;
        logic [K_W-1:0]    rank;
        logic [DIST_W-1:0] dist_sq;
        logic              found;
        logic              last;
    } nbr_result_t;

    typedef struct {
        bit                      is_reg;
        logic [FUNC_W-1:0]       func;
        logic signed [COORD_BITS-1:0] x, y, z;
        logic [IDX_W-1:0]        q;
        logic [APB_DATA_W-1:0]   reg_val;
        bit                      typed;
        nbr_result_t             want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    knn_cmd_if cmd();
    knn_res_if res();

    k_nearest_neighbor_search_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    point_t      cloud [MAX_POINTS];
    int          stored_total;
    int          k_setting;
    nbr_result_t pending_neighbors [$];
    stim_row_t   directed [$];

    int mismatch_count;
    int results_seen;
    int commands_taken;
    bit quiet_phase;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic string fmt_result(nbr_result_t r);
        return $sformatf("src=%0d nbr=%0d rank=%0d dist_sq=%0d found=%0b last=%0b",
                         r.src, r.nbr, r.rank, r.dist_sq, r.found, r.last);
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    function automatic void queue_result(nbr_result_t r);
        pending_neighbors.insert(pending_neighbors.size(), r);
    endfunction

    function automatic void add_row(stim_row_t row);
        directed.insert(directed.size(), row);
    endfunction

    function automatic int clamp_k(logic [APB_DATA_W-1:0] v);
        int c;
        c = int'(v[4:0]);
        if (c < 1)
            c = 1;
        if (c > MAX_K)
            c = MAX_K;
        return c;
    endfunction

    // Brute-force top-k over the stored cloud; ties keep the lower index first.
    function automatic void predict_neighbors(logic [IDX_W-1:0] q);
        longint      best_d [MAX_K];
        int          best_i [MAX_K];
        int          cnt, pos, j;
        longint      dx, dy, dz, d;
        nbr_result_t r;
        cnt = 0;
        r = '0;
        r.src = q;
        r.last = 1'b1;
        if (int'(q) < stored_total) begin
            for (j = 0; j < stored_total; j++) begin
                if (j == int'(q))
                    continue;
                dx = longint'(cloud[q].x) - longint'(cloud[j].x);
                dy = longint'(cloud[q].y) - longint'(cloud[j].y);
                dz = longint'(cloud[q].z) - longint'(cloud[j].z);
                d = dx * dx + dy * dy + dz * dz;
                if (cnt < k_setting) begin
                    pos = cnt;
                    cnt++;
                end
                else if (d >= best_d[k_setting - 1])
                    continue;
                else
                    pos = k_setting - 1;
                while (pos > 0 && best_d[pos - 1] > d) begin
                    best_d[pos] = best_d[pos - 1];
                    best_i[pos] = best_i[pos - 1];
                    pos--;
                end
                best_d[pos] = d;
                best_i[pos] = j;
            end
        end
        if (cnt == 0) begin
            queue_result(r);
            return;
        end
        for (j = 0; j < cnt; j++) begin
            r.nbr = IDX_W'(best_i[j]);
            r.rank = K_W'(j);
            r.dist_sq = DIST_W'(best_d[j]);
            r.found = 1'b1;
            r.last = (j == cnt - 1);
            queue_result(r);
        end
    endfunction

    function automatic void apply_cmd(stim_row_t row);
        case (row.func)
            FUNC_CLEAR:
                stored_total = 0;
            FUNC_APPEND:
                if (stored_total < MAX_POINTS) begin
                    cloud[stored_total] = '{row.x, row.y, row.z};
                    stored_total++;
                end
            FUNC_QUERY:
                if (row.typed)
                    queue_result(row.want);
                else
                    predict_neighbors(row.q);
            default:
                ;
        endcase
    endfunction

    function automatic stim_row_t cmd_row(logic [FUNC_W-1:0] f,
                                          logic signed [COORD_BITS-1:0] x,
                                          logic signed [COORD_BITS-1:0] y,
                                          logic signed [COORD_BITS-1:0] z,
                                          logic [IDX_W-1:0] q);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.func = f;
        r.x = x;
        r.y = y;
        r.z = z;
        r.q = q;
        r.reg_val = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [APB_DATA_W-1:0] v);
        stim_row_t r;
        r = cmd_row(FUNC_NOP, '0, '0, '0, '0);
        r.is_reg = 1'b1;
        r.reg_val = v;
        return r;
    endfunction

    // bad index or lone point: one result with found low
    function automatic stim_row_t miss_row(logic [IDX_W-1:0] q);
        stim_row_t r;
        r = cmd_row(FUNC_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    COORD_BITS'($urandom), q);
        r.typed = 1'b1;
        r.want = '{src: q, nbr: '0, rank: '0, dist_sq: '0, found: 1'b0, last: 1'b1};
        return r;
    endfunction

    // single neighbor with k = 1
    function automatic stim_row_t hit_row(logic [IDX_W-1:0] q, logic [IDX_W-1:0] nbr,
                                          logic [DIST_W-1:0] d);
        stim_row_t r;
        r = miss_row(q);
        r.want = '{src: q, nbr: nbr, rank: '0, dist_sq: d, found: 1'b1, last: 1'b1};
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(int spread);
        int mode;
        mode = ($urandom_range(0, 4) == 0) ? 0 : spread;
        case (mode)
            1: return COORD_BITS'($urandom_range(0, 6) - 3);
            2:
                case ($urandom_range(0, 2))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    default: return 16'sh0000;
                endcase
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic put_cmd(stim_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.func <= row.func;
        cmd.coord_x <= row.x;
        cmd.coord_y <= row.y;
        cmd.coord_z <= row.z;
        cmd.query_index <= row.q;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        apply_cmd(row);
        if (row.func != FUNC_NOP)
            commands_taken++;
    endtask

    task automatic settle(int cycles);
        cmd.valid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    // write, then read back the clamped value
    task automatic write_k(logic [APB_DATA_W-1:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_NEIGHBOR_COUNT;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        k_setting = clamp_k(v);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_DATA_W'(k_setting))
            note_mismatch($sformatf("neighbor_count readback exp=%0d got=%0d",
                                    k_setting, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_row(stim_row_t row);
        if (row.is_reg) begin
            settle(SETTLE_CYCLES);
            write_k(row.reg_val);
        end
        else
            put_cmd(row);
    endtask

    task automatic add_noise();
        case ($urandom_range(0, 11))
            0: put_cmd(cmd_row(FUNC_NOP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                               COORD_BITS'($urandom), IDX_W'($urandom)));
            1:
                if (stored_total < MAX_POINTS)
                    put_cmd(cmd_row(FUNC_QUERY, COORD_BITS'($urandom),
                                    COORD_BITS'($urandom), COORD_BITS'($urandom),
                                    IDX_W'($urandom_range(stored_total, MAX_POINTS - 1))));
            default:
                ;
        endcase
    endtask

    // clear, build a cloud, then query stored points, with noise mixed in
    task automatic run_cloud(bit fill);
        int n, nq, i, spread;
        spread = $urandom_range(0, 2);
        if (fill)
            n = MAX_POINTS + $urandom_range(2, 5);
        else
            n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
        put_cmd(cmd_row(FUNC_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                        COORD_BITS'($urandom), IDX_W'($urandom)));
        for (i = 0; i < n; i++) begin
            add_noise();
            put_cmd(cmd_row(FUNC_APPEND, pick_coord(spread), pick_coord(spread),
                            pick_coord(spread), IDX_W'($urandom)));
        end
        nq = $urandom_range(3, 8);
        for (i = 0; i < nq; i++) begin
            add_noise();
            put_cmd(cmd_row(FUNC_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
                            COORD_BITS'($urandom),
                            IDX_W'($urandom_range(0, stored_total - 1))));
        end
    endtask

    always @(posedge clk)
    begin
        nbr_result_t got;
        if (rst_n && res.valid && res.ready) begin
            got = '{res.source_index, res.neighbor_index, res.rank, res.distance_sq,
                    res.found, res.last};
            results_seen++;
            if (pending_neighbors.size() == 0)
                note_mismatch($sformatf("unexpected result item %s", fmt_result(got)));
            else if (got !== pending_neighbors[0])
                note_mismatch($sformatf("exp %s, got %s",
                                        fmt_result(pending_neighbors.pop_front()),
                                        fmt_result(got)));
            else
                void'(pending_neighbors.pop_front());
        end
    end

    // result side: random stalls, plus one long hold-off to back up the core
    initial
    begin
        int  run;
        bit  level;
        bit  hold_done;
        res.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!hold_done && results_seen >= 40 && cmd.valid) begin
                hold_done = 1'b1;
                @(posedge clk);
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet_phase) begin
                @(posedge clk);
                res.ready <= 1'b1;
            end
            else begin
                run = $urandom_range(0, 19);
                level = (run < 13);
                if (run < 13)
                    run = $urandom_range(1, 8);
                else if (run < 19)
                    run = $urandom_range(1, 3);
                else
                    run = $urandom_range(10, 40);
                repeat (run) begin
                    @(posedge clk);
                    res.ready <= level;
                end
            end
        end
    end

    initial
    begin
        int        i, p;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.func = FUNC_NOP;
        cmd.coord_x = '0;
        cmd.coord_y = '0;
        cmd.coord_z = '0;
        cmd.query_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stored_total = 0;
        k_setting = 1;
        mismatch_count = 0;
        results_seen = 0;
        commands_taken = 0;
        quiet_phase = 1'b0;

        add_row(miss_row(0));                  // empty store after reset
        add_row(miss_row(63));
        add_row(cmd_row(FUNC_NOP, 16'sh7fff, 16'sh8000, 16'sh5a5a, 6'h2a));
        add_row(cmd_row(FUNC_APPEND, 16'sh8000, 16'sh8000, 16'sh8000, 6'h3f));
        add_row(miss_row(0));                  // lone point, no neighbor
        add_row(cmd_row(FUNC_APPEND, 16'sh7fff, 16'sh7fff, 16'sh7fff, 6'h00));
        add_row(hit_row(0, 1, FAR_CORNER_DIST));
        add_row(hit_row(1, 0, FAR_CORNER_DIST));
        add_row(miss_row(2));
        add_row(reg_row(31));                  // clamps to MAX_K
        add_row(cmd_row(FUNC_APPEND, 16'sh0000, 16'sh0000, 16'sh0000, 6'h15));
        add_row(cmd_row(FUNC_APPEND, 16'sh0001, 16'sh0000, 16'sh0000, 6'h00));
        add_row(cmd_row(FUNC_APPEND, -16'sh0001, 16'sh0000, 16'sh0000, 6'h00));
        add_row(cmd_row(FUNC_APPEND, 16'sh0000, 16'sh0000, -16'sh0001, 6'h00));
        add_row(cmd_row(FUNC_QUERY, 16'sh1234, 16'sh4321, 16'sh0f0f, 6'd2));
        add_row(cmd_row(FUNC_QUERY, 16'shedcb, 16'sh2222, 16'sh7777, 6'd0));
        add_row(cmd_row(FUNC_CLEAR, 16'sh5555, 16'shaaaa, 16'sh3333, 6'h3f));
        add_row(miss_row(0));
        add_row(cmd_row(FUNC_APPEND, 16'sh0005, 16'sh0005, 16'sh0005, 6'h00));
        add_row(cmd_row(FUNC_APPEND, 16'sh0005, 16'sh0005, 16'sh0005, 6'h00));
        add_row(reg_row(0));                   // clamps up to 1
        add_row(hit_row(1, 0, '0));            // coincident points
        add_row(reg_row(21));
        add_row(cmd_row(FUNC_APPEND, -16'sh0007, 16'sh0009, 16'sh0003, 6'h00));
        add_row(cmd_row(FUNC_QUERY, 16'sh0000, 16'sh0000, 16'sh0000, 6'd2));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed.size(); i++)
            apply_row(directed[i]);

        commands_taken = 0;
        for (p = 0; commands_taken < RANDOM_ITEMS; p++) begin
            settle(SETTLE_CYCLES);
            quiet_phase = (p % 4 == 1);
            write_k((p < 8) ? APB_DATA_W'(K_SWEEP[p]) : APB_DATA_W'($urandom));
            run_cloud(p == 2);
        end

        settle(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/knn_pkg.sv
rtl/core/knn_chan_if.sv
rtl/core/knn_point_mem.sv
rtl/core/knn_dist.sv
rtl/core/knn_topk.sv
rtl/core/k_nearest_neighbor_search_core.sv
sim/tb.sv
